// ===== rtl/tnaf_pkg.sv =====
package tnaf_pkg;

  // field widths
  localparam int COORD_BITS = 20;
  localparam int ID_BITS    = 16;
  localparam int CFG_W      = 16;

  // reset value of the cosine limit, 0.5 in Q1.15 (60 degrees)
  localparam logic signed [CFG_W-1:0] COS_RESET = CFG_W'(16384);

  // edge vectors, cross product terms and normal components
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int N_W    = PROD_W;
  localparam int MAG_W  = N_W - 1;

  // normal magnitude split into high and low halves for squaring
  localparam int LO_W = (MAG_W + 1) / 2;
  localparam int HI_W = MAG_W - LO_W;
  localparam int SQ_W = 2 * MAG_W;
  localparam int N2_W = SQ_W + 2;

  // squared cosine and the right-hand product, cut into chunks of |n|^2
  localparam int C2_W     = 2 * CFG_W - 1;
  localparam int NCH      = 3;
  localparam int CH_W     = (N2_W + NCH - 1) / NCH;
  localparam int N2P_W    = NCH * CH_W;
  localparam int RP_W     = C2_W + CH_W;
  localparam int CMP_W    = C2_W + N2_W;
  localparam int SCALE_SH = 2 * CFG_W - 2;

  // vertex ids of one triangle
  typedef struct packed {
    logic [ID_BITS-1:0] id_a;
    logic [ID_BITS-1:0] id_b;
    logic [ID_BITS-1:0] id_c;
  } ids_t;

  // face normal handed from the cross product to the angle test
  typedef struct packed {
    logic signed [N_W-1:0] nx;
    logic signed [N_W-1:0] ny;
    logic signed [N_W-1:0] nz;
    ids_t                  ids;
  } nrm_t;

  // side-band flags that travel with the angle test
  typedef struct packed {
    logic degen;
    logic nz_neg;
    logic nz_zero;
    logic c_neg;
    ids_t ids;
  } meta_t;

  // sign-extend a coordinate to the edge width
  function automatic logic signed [DIFF_W-1:0] ext_coord(
    input logic signed [COORD_BITS-1:0] a
  );
    return DIFF_W'(a);
  endfunction

  // magnitude of a normal component
  function automatic logic [MAG_W-1:0] mag_n(input logic signed [N_W-1:0] a);
    logic signed [N_W-1:0] t;
    t = a[N_W-1] ? -a : a;
    return t[MAG_W-1:0];
  endfunction

endpackage

// ===== rtl/tnaf_tri_if.sv =====
interface tnaf_tri_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tnaf_pkg::COORD_BITS-1:0] ax;
  logic signed [tnaf_pkg::COORD_BITS-1:0] ay;
  logic signed [tnaf_pkg::COORD_BITS-1:0] az;
  logic signed [tnaf_pkg::COORD_BITS-1:0] bx;
  logic signed [tnaf_pkg::COORD_BITS-1:0] by_coord;
  logic signed [tnaf_pkg::COORD_BITS-1:0] bz;
  logic signed [tnaf_pkg::COORD_BITS-1:0] cx;
  logic signed [tnaf_pkg::COORD_BITS-1:0] cy;
  logic signed [tnaf_pkg::COORD_BITS-1:0] cz;
  logic        [tnaf_pkg::ID_BITS-1:0]    id_a;
  logic        [tnaf_pkg::ID_BITS-1:0]    id_b;
  logic        [tnaf_pkg::ID_BITS-1:0]    id_c;

  modport source (
    output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, id_a, id_b, id_c,
    input  ready
  );
  modport sink (
    input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, id_a, id_b, id_c,
    output ready
  );
endinterface

// ===== rtl/tnaf_res_if.sv =====
interface tnaf_res_if;
  logic                                valid;
  logic                                ready;
  logic                                keep;
  logic                                degenerate;
  logic [tnaf_pkg::ID_BITS-1:0]        out_id_a;
  logic [tnaf_pkg::ID_BITS-1:0]        out_id_b;
  logic [tnaf_pkg::ID_BITS-1:0]        out_id_c;

  modport source (
    output valid, keep, degenerate, out_id_a, out_id_b, out_id_c,
    input  ready
  );
  modport sink (
    input  valid, keep, degenerate, out_id_a, out_id_b, out_id_c,
    output ready
  );
endinterface

// ===== rtl/tnaf_cross.sv =====
module tnaf_cross (
  input  logic           clk,
  input  logic           rst_n,
  tnaf_tri_if.sink       in_tri,
  output logic           nrm_valid,
  input  logic           nrm_ready,
  output tnaf_pkg::nrm_t nrm
);
  import tnaf_pkg::*;

  localparam int NST = 3;

  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;

  logic signed [DIFF_W-1:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic signed [PROD_W-1:0] p_uxvy_r, p_uyvx_r, p_uzvx_r, p_uxvz_r, p_uyvz_r, p_uzvy_r;
  logic signed [N_W-1:0]    nx_r, ny_r, nz_r;
  ids_t                     ids0_r, ids1_r, ids2_r;

  // stage ready: a stage takes a request when empty or when it moves on
  always_comb begin
    rdy[NST] = nrm_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_tri.ready = rdy[0];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_tri.valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 0: edge vectors from vertex a
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ux_r   <= ext_coord(in_tri.bx) - ext_coord(in_tri.ax);
      uy_r   <= ext_coord(in_tri.by_coord) - ext_coord(in_tri.ay);
      uz_r   <= ext_coord(in_tri.bz) - ext_coord(in_tri.az);
      vx_r   <= ext_coord(in_tri.cx) - ext_coord(in_tri.ax);
      vy_r   <= ext_coord(in_tri.cy) - ext_coord(in_tri.ay);
      vz_r   <= ext_coord(in_tri.cz) - ext_coord(in_tri.az);
      ids0_r <= '{id_a: in_tri.id_a, id_b: in_tri.id_b, id_c: in_tri.id_c};
    end
  end

  // stage 1: the six cross product terms
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p_uxvy_r <= PROD_W'(ux_r) * PROD_W'(vy_r);
      p_uyvx_r <= PROD_W'(uy_r) * PROD_W'(vx_r);
      p_uzvx_r <= PROD_W'(uz_r) * PROD_W'(vx_r);
      p_uxvz_r <= PROD_W'(ux_r) * PROD_W'(vz_r);
      p_uyvz_r <= PROD_W'(uy_r) * PROD_W'(vz_r);
      p_uzvy_r <= PROD_W'(uz_r) * PROD_W'(vy_r);
      ids1_r   <= ids0_r;
    end
  end

  // stage 2: normal components
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      nx_r   <= p_uyvz_r - p_uzvy_r;
      ny_r   <= p_uzvx_r - p_uxvz_r;
      nz_r   <= p_uxvy_r - p_uyvx_r;
      ids2_r <= ids1_r;
    end
  end

  assign nrm_valid = v_r[NST-1];
  assign nrm       = '{nx: nx_r, ny: ny_r, nz: nz_r, ids: ids2_r};

  // back-pressure reaches the input only once every stage holds a request
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !rdy[0] |-> (&v_r))
    else $error("input blocked with an empty stage");

endmodule

// ===== rtl/tnaf_norm.sv =====
module tnaf_norm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              nrm_valid,
  output logic                              nrm_ready,
  input  tnaf_pkg::nrm_t                    nrm,
  input  logic signed [tnaf_pkg::CFG_W-1:0] cos_limit,
  tnaf_res_if.source                        out_res
);
  import tnaf_pkg::*;

  localparam int NST = 6;

  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;
  meta_t          meta_r [NST-1];

  logic [2*HI_W-1:0]      hh_r [3];
  logic [HI_W+LO_W-1:0]   hl_r [3];
  logic [2*LO_W-1:0]      ll_r [3];
  logic [C2_W-1:0]        c2_r [4];
  logic [SQ_W-1:0]        sq_r [3];
  logic [SQ_W-1:0]        sz2_r, sz3_r;
  logic [N2_W-1:0]        n2_r;
  logic [RP_W-1:0]        rp_r [NST-3];
  logic [CMP_W-1:0]       lhs_r, rhs_r;
  logic                   keep_r, degen_r;
  ids_t                   ids_out_r;

  logic [MAG_W-1:0]       mag     [3];
  logic [CFG_W-1:0]       cmag;
  meta_t                  meta_nxt;
  logic [N2P_W-1:0]       n2p;
  logic [CMP_W-1:0]       rhs_nxt;
  logic                   keep_nxt;

  // stage ready
  always_comb begin
    rdy[NST] = out_res.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign nrm_ready = rdy[0];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= nrm_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // side-band flags and magnitudes feeding stage 0
  always_comb begin
    mag[0] = mag_n(nrm.nx);
    mag[1] = mag_n(nrm.ny);
    mag[2] = mag_n(nrm.nz);
    cmag   = cos_limit[CFG_W-1] ? CFG_W'(-cos_limit) : CFG_W'(cos_limit);
    meta_nxt.degen   = (nrm.nx == '0) && (nrm.ny == '0) && (nrm.nz == '0);
    meta_nxt.nz_neg  = nrm.nz[N_W-1];
    meta_nxt.nz_zero = (nrm.nz == '0);
    meta_nxt.c_neg   = cos_limit[CFG_W-1];
    meta_nxt.ids     = nrm.ids;
  end

  // flags follow their request stage by stage
  always_ff @(posedge clk) begin
    if (rdy[0]) meta_r[0] <= meta_nxt;
    for (int k = 1; k < NST - 1; k++) begin
      if (rdy[k]) meta_r[k] <= meta_r[k-1];
    end
  end

  // stage 0: partial squares of each component, squared cosine
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= (2*HI_W)'(mag[i][MAG_W-1:LO_W]) * (2*HI_W)'(mag[i][MAG_W-1:LO_W]);
        hl_r[i] <= (HI_W+LO_W)'(mag[i][MAG_W-1:LO_W]) * (HI_W+LO_W)'(mag[i][LO_W-1:0]);
        ll_r[i] <= (2*LO_W)'(mag[i][LO_W-1:0]) * (2*LO_W)'(mag[i][LO_W-1:0]);
      end
      c2_r[0] <= C2_W'((2*CFG_W)'(cmag) * (2*CFG_W)'(cmag));
    end
  end

  // stage 1: full squares
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= (SQ_W'(hh_r[i]) << (2 * LO_W)) + (SQ_W'(hl_r[i]) << (LO_W + 1))
                   + SQ_W'(ll_r[i]);
      end
      c2_r[1] <= c2_r[0];
    end
  end

  // stage 2: squared length of the normal
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      n2_r    <= N2_W'(sq_r[0]) + N2_W'(sq_r[1]) + N2_W'(sq_r[2]);
      sz2_r   <= sq_r[2];
      c2_r[2] <= c2_r[1];
    end
  end

  // stage 3: cosine squared times each chunk of the length
  assign n2p = N2P_W'(n2_r);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int k = 0; k < NCH; k++) begin
        rp_r[k] <= RP_W'(c2_r[2]) * RP_W'(n2p[k*CH_W +: CH_W]);
      end
      sz3_r   <= sz2_r;
      c2_r[3] <= c2_r[2];
    end
  end

  // stage 4: assemble both sides of the compare
  always_comb begin
    rhs_nxt = '0;
    for (int k = 0; k < NCH; k++) begin
      rhs_nxt = rhs_nxt + (CMP_W'(rp_r[k]) << (k * CH_W));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      rhs_r <= (c2_r[3] == '0) ? '0 : rhs_nxt;
      lhs_r <= CMP_W'(sz3_r) << SCALE_SH;
    end
  end

  // stage 5: angle decision into the output register
  always_comb begin
    if (meta_r[4].degen) begin
      keep_nxt = 1'b0;
    end else if (meta_r[4].c_neg) begin
      keep_nxt = !meta_r[4].nz_neg || (lhs_r < rhs_r);
    end else begin
      keep_nxt = !meta_r[4].nz_neg && !meta_r[4].nz_zero && (lhs_r > rhs_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      keep_r    <= keep_nxt;
      degen_r   <= meta_r[4].degen;
      ids_out_r <= meta_r[4].ids;
    end
  end

  assign out_res.valid      = v_r[NST-1];
  assign out_res.keep       = keep_r;
  assign out_res.degenerate = degen_r;
  assign out_res.out_id_a   = ids_out_r.id_a;
  assign out_res.out_id_b   = ids_out_r.id_b;
  assign out_res.out_id_c   = ids_out_r.id_c;

  // a zero normal is never kept
  a_degen_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.degenerate |-> !out_res.keep)
    else $error("degenerate triangle flagged as kept");

  // a stalled result stays put
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |=> out_res.valid && $stable(keep_r)
      && $stable(ids_out_r))
    else $error("stalled result changed");

endmodule

// ===== rtl/triangle_normal_angle_filter.sv =====
// channel   dir  handshake        content
// in_tri    in   valid / ready    vertices a, b, c (Q16.4) and their ids
// out_res   out  valid / ready    keep, degenerate and the ids passed through
// cfg       in   cfg_we           cos_limit, signed Q1.15
//
// one triangle per clock sustained while the output accepts results; each request passes
// through the three-stage cross product and six-stage angle test pipeline
// synchronous active-low reset empties the pipeline and sets cos_limit to 0.5
// a stall at the output fills empty stages first; input ready drops only
// once every stage holds a request, and nothing is lost or repeated
module triangle_normal_angle_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  tnaf_tri_if.sink                          in_tri,
  tnaf_res_if.source                        out_res,
  input  logic                              cfg_we,
  input  logic signed [tnaf_pkg::CFG_W-1:0] cfg_wdata
);
  import tnaf_pkg::*;

  logic signed [CFG_W-1:0] cos_limit_r;
  logic                    nrm_valid;
  logic                    nrm_ready;
  nrm_t                    nrm;

  // cosine limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_limit_r <= COS_RESET;
    end else if (cfg_we) begin
      cos_limit_r <= cfg_wdata;
    end
  end

  // face normal
  tnaf_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tri    (in_tri),
    .nrm_valid (nrm_valid),
    .nrm_ready (nrm_ready),
    .nrm       (nrm)
  );

  // angle test against the limit
  tnaf_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .nrm_valid (nrm_valid),
    .nrm_ready (nrm_ready),
    .nrm       (nrm),
    .cos_limit (cos_limit_r),
    .out_res   (out_res)
  );

endmodule

// ===== test/triangle_normal_angle_filter_checker.sv =====
`timescale 1ns / 1ps

module triangle_normal_angle_filter_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  tnaf_tri_if                               tri_mon,
  tnaf_res_if                               res_mon,
  input  logic                              cfg_we,
  input  logic signed [tnaf_pkg::CFG_W-1:0] cfg_wdata,
  output int unsigned                       mismatches,
  output int unsigned                       awaiting,
  output int unsigned                       kept_total,
  output int unsigned                       degen_total
);
  import tnaf_pkg::*;

  typedef struct {
    logic               keep;
    logic               degenerate;
    logic [ID_BITS-1:0] id_a;
    logic [ID_BITS-1:0] id_b;
    logic [ID_BITS-1:0] id_c;
    int unsigned        seq;
  } verdict_t;

  verdict_t                verdicts[$];
  logic signed [CFG_W-1:0] limit_q;
  int unsigned             tri_seq;

  // exact cone test on the face normal, all terms at full width
  function automatic verdict_t judge_face(
    input logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz,
    input logic signed [CFG_W-1:0]      limit
  );
    logic signed [63:0] ux, uy, uz, vx, vy, vz, nx, ny, nz, lim;
    logic [159:0]       mx, my, mz, mc, norm_sq, lhs, rhs;
    verdict_t           v;
    ux  = bx - ax;
    uy  = by - ay;
    uz  = bz - az;
    vx  = cx - ax;
    vy  = cy - ay;
    vz  = cz - az;
    nx  = uy * vz - uz * vy;
    ny  = uz * vx - ux * vz;
    nz  = ux * vy - uy * vx;
    lim = limit;
    mx  = (nx < 0) ? 160'(-nx) : 160'(nx);
    my  = (ny < 0) ? 160'(-ny) : 160'(ny);
    mz  = (nz < 0) ? 160'(-nz) : 160'(nz);
    mc  = (lim < 0) ? 160'(-lim) : 160'(lim);
    norm_sq = mx * mx + my * my + mz * mz;
    lhs = (mz * mz) << 30;
    rhs = mc * mc * norm_sq;
    v.degenerate = (nx == 0) && (ny == 0) && (nz == 0);
    if (v.degenerate) begin
      v.keep = 1'b0;
    end else if (lim >= 0) begin
      v.keep = (nz > 0) && (lhs > rhs);
    end else begin
      v.keep = (nz >= 0) || (lhs < rhs);
    end
    return v;
  endfunction

  // one line per mismatch, and count it
  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int unsigned seq,
                             input logic [ID_BITS-1:0] want,
                             input logic [ID_BITS-1:0] got);
    if (got !== want)
      flag_mismatch($sformatf("triangle %0d %s: expected %0h, got %0h",
                              seq, name, want, got));
  endtask

  // predict on each accepted triangle, compare on each accepted result
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      limit_q     = COS_RESET;
      tri_seq     = 0;
      mismatches  = 0;
      kept_total  = 0;
      degen_total = 0;
      verdicts.delete();
    end else begin
      if (tri_mon.valid && tri_mon.ready) begin
        want = judge_face(tri_mon.ax, tri_mon.ay, tri_mon.az,
                          tri_mon.bx, tri_mon.by_coord, tri_mon.bz,
                          tri_mon.cx, tri_mon.cy, tri_mon.cz, limit_q);
        want.id_a = tri_mon.id_a;
        want.id_b = tri_mon.id_b;
        want.id_c = tri_mon.id_c;
        want.seq  = tri_seq;
        tri_seq++;
        if (want.keep) kept_total++;
        if (want.degenerate) degen_total++;
        verdicts.push_back(want);
      end
      if (res_mon.valid && res_mon.ready) begin
        if (verdicts.size() == 0) begin
          flag_mismatch("result request with no triangle outstanding");
        end else begin
          want = verdicts.pop_front();
          check_field("keep", want.seq, ID_BITS'(want.keep), ID_BITS'(res_mon.keep));
          check_field("degenerate", want.seq, ID_BITS'(want.degenerate),
                      ID_BITS'(res_mon.degenerate));
          check_field("id_a", want.seq, want.id_a, res_mon.out_id_a);
          check_field("id_b", want.seq, want.id_b, res_mon.out_id_b);
          check_field("id_c", want.seq, want.id_c, res_mon.out_id_c);
        end
      end
      if (cfg_we) limit_q = cfg_wdata;
    end
    awaiting = verdicts.size();
  end

endmodule

// ===== test/triangle_normal_angle_filter_tb.sv =====
`timescale 1ns / 1ps

module triangle_normal_angle_filter_tb;
  import tnaf_pkg::*;

  localparam int RESET_CYCLES    = 12;
  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 65;
  localparam int HOLD_OFF_CYCLES = 96;
  localparam int DRAIN_CYCLES    = 12;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NEAR_SPAN       = 1 << 18;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax, ay, az, bx, by_coord, bz, cx, cy, cz;
    logic [ID_BITS-1:0]           id_a, id_b, id_c;
  } face_t;

  typedef enum int {
    FACE_SMALL, FACE_WIDE, FACE_FLAT, FACE_EDGE_ON, FACE_COLLINEAR, FACE_CORNER
  } face_kind_e;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic signed [CFG_W-1:0] cfg_wdata;
  int unsigned             mismatches, awaiting, kept_total, degen_total;
  int unsigned             faces_sent = 0;
  int unsigned             settings_seen = 1;
  int unsigned             quiet_cycles = 0;
  bit                      calm = 1'b0;
  bit                      hold_off = 1'b0;

  tnaf_tri_if tri_ch ();
  tnaf_res_if res_ch ();

  triangle_normal_angle_filter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tri    (tri_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  triangle_normal_angle_filter_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tri_mon     (tri_ch),
    .res_mon     (res_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .awaiting    (awaiting),
    .kept_total  (kept_total),
    .degen_total (degen_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // coordinates wrap to the field width, ids are random
  function automatic face_t make_face(input int ax, ay, az, bx, by, bz, cx, cy, cz);
    face_t f;
    f.ax       = COORD_BITS'(ax);
    f.ay       = COORD_BITS'(ay);
    f.az       = COORD_BITS'(az);
    f.bx       = COORD_BITS'(bx);
    f.by_coord = COORD_BITS'(by);
    f.bz       = COORD_BITS'(bz);
    f.cx       = COORD_BITS'(cx);
    f.cy       = COORD_BITS'(cy);
    f.cz       = COORD_BITS'(cz);
    f.id_a     = ID_BITS'($urandom);
    f.id_b     = ID_BITS'($urandom);
    f.id_c     = ID_BITS'($urandom);
    return f;
  endfunction

  // face whose normal is (nx, 0, nz)
  function automatic face_t face_with_normal(input int nx, nz);
    return make_face(0, 0, 0, 0, 1, 0, -nz, 0, nx);
  endfunction

  function automatic int rand_coord(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic face_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return FACE_SMALL;
    if (r < 6) return FACE_WIDE;
    if (r == 6) return FACE_FLAT;
    if (r == 7) return FACE_EDGE_ON;
    if (r == 8) return FACE_COLLINEAR;
    return FACE_CORNER;
  endfunction

  function automatic face_t random_face(input face_kind_e kind);
    int a[3], b[3], c[3], d[3], k;
    int corners[4];
    corners = '{-524288, 524287, 0, -1};
    for (int i = 0; i < 3; i++) begin
      a[i] = rand_coord(NEAR_SPAN);
      b[i] = a[i] + rand_coord(300);
      c[i] = a[i] + rand_coord(300);
    end
    case (kind)
      FACE_WIDE: begin
        return make_face($urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
      end
      // all in one z plane: normal along +z or -z
      FACE_FLAT: begin
        a[2] = rand_coord(524287);
        b[2] = a[2];
        c[2] = a[2];
      end
      // shared y: normal lies in the xy plane
      FACE_EDGE_ON: begin
        b[1] = a[1];
        c[1] = a[1];
      end
      // c on the line through a and b, sometimes all three together
      FACE_COLLINEAR: begin
        k = rand_coord(3);
        for (int i = 0; i < 3; i++) begin
          d[i] = ($urandom_range(0, 3) == 0) ? 0 : rand_coord(500);
          b[i] = a[i] + d[i];
          c[i] = a[i] + k * d[i];
        end
      end
      FACE_CORNER: begin
        for (int i = 0; i < 3; i++) begin
          a[i] = corners[$urandom_range(0, 3)];
          b[i] = corners[$urandom_range(0, 3)];
          c[i] = corners[$urandom_range(0, 3)];
        end
      end
      default: ;
    endcase
    return make_face(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2]);
  endfunction

  task automatic load_payload(input face_t f);
    tri_ch.ax       <= f.ax;
    tri_ch.ay       <= f.ay;
    tri_ch.az       <= f.az;
    tri_ch.bx       <= f.bx;
    tri_ch.by_coord <= f.by_coord;
    tri_ch.bz       <= f.bz;
    tri_ch.cx       <= f.cx;
    tri_ch.cy       <= f.cy;
    tri_ch.cz       <= f.cz;
    tri_ch.id_a     <= f.id_a;
    tri_ch.id_b     <= f.id_b;
    tri_ch.id_c     <= f.id_c;
  endtask

  // offer one triangle after a random gap, return at the falling edge after acceptance
  task automatic send_face(input face_t f);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      tri_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    load_payload(f);
    tri_ch.valid <= 1'b1;
    @(posedge clk);
    while (!tri_ch.ready) @(posedge clk);
    @(negedge clk);
    faces_sent++;
  endtask

  // write the cosine limit once the pipeline has drained
  task automatic set_limit(input int limit);
    tri_ch.valid <= 1'b0;
    wait (awaiting == 0);
    repeat (DRAIN_CYCLES + 1) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(limit);
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_seen++;
  endtask

  // result side: random stalls per request, one long hold-off on demand
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = calm ? 0 : $urandom_range(0, 7);
      if (hold_off) begin
        stall    = stall + HOLD_OFF_CYCLES;
        hold_off = 1'b0;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  // watchdog on cycles with no request moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (tri_ch.valid && tri_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    face_t f;
    int    limits[N_PHASES];
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    tri_ch.valid = 1'b0;
    load_payload('0);
    limits = '{16384, 32767, -32768, 0, -1, 1, 23170, -16384,
               int'($urandom_range(0, 65535)) - 32768,
               int'($urandom_range(0, 65535)) - 32768};
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limit of 60 degrees
    send_face(make_face(0, 0, 0, 16, 0, 0, 0, 16, 0));
    send_face(make_face(0, 0, 0, 0, 16, 0, 16, 0, 0));
    send_face(make_face(0, 0, 0, 16, 0, 0, 0, 0, 16));
    // just inside and just outside the cone
    send_face(face_with_normal(173, 100));
    send_face(face_with_normal(174, 100));
    send_face(face_with_normal(0, -50));
    // coincident vertices at both coordinate extremes, with id extremes
    f = make_face(524287, 524287, 524287, 524287, 524287, 524287, 524287, 524287, 524287);
    f.id_a = '1;
    f.id_b = '1;
    f.id_c = '1;
    send_face(f);
    f = make_face(-524288, -524288, -524288, -524288, -524288, -524288,
                  -524288, -524288, -524288);
    f.id_a = '0;
    f.id_b = '0;
    f.id_c = '0;
    send_face(f);
    send_face(make_face(0, 0, 0, 1, 2, 3, 2, 4, 6));
    // widest edges, both windings, then full-range skewed faces
    send_face(make_face(-524288, -524288, 0, 524287, -524288, 0, -524288, 524287, 0));
    send_face(make_face(-524288, -524288, 0, -524288, 524287, 0, 524287, -524288, 0));
    send_face(make_face(-524288, -524288, -524288, 524287, 524287, -524288,
                        524287, -524288, 524287));
    send_face(make_face(524287, -524288, 524287, -524288, 524287, 524287,
                        -524288, -524288, -524288));

    // most negative limit: only a normal exactly along -z is dropped
    set_limit(-32768);
    send_face(face_with_normal(0, 7));
    send_face(face_with_normal(0, -7));
    send_face(face_with_normal(1, -100));
    send_face(face_with_normal(5, 0));

    // zero limit: a normal lying in the xy plane sits exactly on the boundary
    set_limit(0);
    send_face(face_with_normal(5, 0));
    send_face(face_with_normal(100000, 1));
    send_face(face_with_normal(3, -1));

    // tightest positive limit
    set_limit(32767);
    send_face(face_with_normal(0, 9));
    send_face(face_with_normal(1, 1000));
    send_face(face_with_normal(1, 100));

    // random phases, one limit each
    for (int p = 0; p < N_PHASES; p++) begin
      set_limit(limits[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 20 == 0) calm = ($urandom_range(0, 3) == 0);
        // back-to-back offers against a long output hold-off
        if (p == 2 && i == 10) begin
          hold_off = 1'b1;
          calm     = 1'b1;
        end
        // sender waits for every outstanding result
        if (p == 5 && i == 32) begin
          tri_ch.valid <= 1'b0;
          wait (awaiting == 0);
          @(negedge clk);
        end
        send_face(random_face(pick_kind()));
      end
    end

    tri_ch.valid <= 1'b0;
    wait (awaiting == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("sent %0d triangles under %0d cosine limits, extremes included",
             faces_sent, settings_seen);
    $display("%0d predicted kept, %0d degenerate; long output hold-off and sender drain done",
             kept_total, degen_total);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
